>>> rtl/core/pairwise_crc8_framer_checker_macros.svh
// ----------------------------------------------------------------------------
// pairwise crc-8 framer / checker assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_CRC8_FRAMER_CHECKER_MACROS_SVH
`define PAIRWISE_CRC8_FRAMER_CHECKER_MACROS_SVH

// same-cycle implication
`define PCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// types, codes and the crc-8 byte step shared by the framer / checker
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_CRC    = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic CFG_POLY = 1'b0;
    localparam logic CFG_INIT = 1'b1;

    localparam logic [7:0] POLY_RESET = 8'h31;
    localparam logic [7:0] INIT_RESET = 8'hFF;

    typedef struct packed {
        logic [7:0] data;
        logic       is_payload;
        logic       pair_ok;
        logic       transfer_ok;
        logic       run_last;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } step_out_t;

    // msb-first crc-8, implicit x^8 term
    function automatic logic [7:0] crc_absorb(
        input logic [7:0] crc,
        input logic [7:0] b,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pcf_engine.sv
// ----------------------------------------------------------------------------
// pcf_engine
// per-byte framing / check step with position, running crc and mismatch state
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_engine
    import pcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       kind,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic [7:0] poly,
    input  wire logic [7:0] init,
    output step_out_t       res
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] crc_reg;
    logic       mismatch_reg;
    logic       mismatch_next;

    logic       is_check;
    logic [1:0] pos_eff;
    logic [7:0] base;
    logic [7:0] crc_new;
    logic       crc_match;
    logic       report;
    logic       two;
    logic       mismatch_now;

    always_comb
    begin
        is_check = (kind == KIND_CHECK);
        case (pos_reg)
            POS_SECOND: pos_eff = POS_SECOND;
            POS_CRC:    pos_eff = is_check ? POS_CRC : POS_FIRST;
            default:    pos_eff = POS_FIRST;
        endcase
        base         = (pos_eff == POS_SECOND) ? crc_reg : init;
        crc_new      = crc_absorb(base, in_byte, poly);
        crc_match    = (in_byte == crc_reg);
        report       = is_check && (pos_eff == POS_CRC);
        two          = !is_check && (pos_eff == POS_SECOND);
        mismatch_now = mismatch_reg | (report & ~crc_match);

        res.two                = two;
        res.first.data         = report ? 8'h00 : in_byte;
        res.first.is_payload   = ~report;
        res.first.pair_ok      = report & crc_match;
        res.first.transfer_ok  = ~mismatch_now;
        res.first.run_last     = ~two;
        res.second.data        = crc_new;
        res.second.is_payload  = 1'b0;
        res.second.pair_ok     = 1'b0;
        res.second.transfer_ok = ~mismatch_now;
        res.second.run_last    = 1'b1;

        if (in_last || report || two)
        begin
            pos_next = POS_FIRST;
        end
        else if (is_check)
        begin
            pos_next = pos_eff + 2'd1;
        end
        else
        begin
            pos_next = POS_SECOND;
        end
        mismatch_next = in_last ? 1'b0 : mismatch_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_FIRST;
            mismatch_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
        end
    end

    // running crc is only read after a byte of the pair has written it
    always_ff @(posedge clk)
    begin
        if (step && !report)
        begin
            crc_reg <= crc_new;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pairwise_crc8_framer_checker.sv
// ----------------------------------------------------------------------------
// pairwise_crc8_framer_checker
// byte-pair crc-8 framer (kind 0) and framed-triple checker (kind 1)
// ----------------------------------------------------------------------------
// A byte word is registered on input, processed combinationally by the engine
// and placed in the output register. One input word is taken per cycle while
// the output side keeps up; the second byte of a framing pair yields two output
// words (the byte and its crc), the crc word waits in a second holding register
// and the input is held while it is sent; check mode runs at one per cycle.
// The output side delivers one word per cycle while out_ready is high and words
// are available. Polynomial and initial value are written through the cfg port;
// the user must write them only while the block is idle, which the block itself
// does not enforce. The initial value is picked up at each pair start.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_crc8_framer_checker
    import pcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [7:0] out_byte,
    output      logic       is_payload,
    output      logic       pair_crc_ok,
    output      logic       transfer_ok,
    output      logic       run_last
);

    logic [7:0] poly_reg;
    logic [7:0] init_reg;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    result_t    out_next;
    logic       pend_valid_reg;
    logic       pend_valid_next;
    result_t    pend_reg;

    logic       out_free;
    logic       advance;
    logic       take_in;
    step_out_t  res;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
            init_reg <= INIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POLY: poly_reg <= cfg_data;
                CFG_INIT: init_reg <= cfg_data;
                default:  poly_reg <= poly_reg;
            endcase
        end
    end

    // handshake control
    always_comb
    begin
        out_free      = !out_valid_reg || out_ready;
        advance       = in_valid_reg && !pend_valid_reg && out_free;
        in_ready      = !in_valid_reg || advance;
        take_in       = in_valid && in_ready;
        in_valid_next = take_in || (in_valid_reg && !advance);

        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pend_valid_next = pend_valid_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (advance)
            begin
                out_next        = res.first;
                out_valid_next  = 1'b1;
                pend_valid_next = res.two;
            end
        end
    end

    pcf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .kind    (kind_reg),
        .in_byte (byte_reg),
        .in_last (last_reg),
        .poly    (poly_reg),
        .init    (init_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            kind_reg <= kind;
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        out_reg <= out_next;
        if (advance && res.two)
        begin
            pend_reg <= res.second;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_reg.data;
    assign is_payload  = out_reg.is_payload;
    assign pair_crc_ok = out_reg.pair_ok;
    assign transfer_ok = out_reg.transfer_ok;
    assign run_last    = out_reg.run_last;

endmodule

`default_nettype wire

>>> rtl/core/pcf_checker.sv
// ----------------------------------------------------------------------------
// pcf_checker
// port-level checks for the pairwise crc-8 framer / checker, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "pairwise_crc8_framer_checker_macros.svh"

module pcf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       is_payload,
    input wire logic       pair_crc_ok,
    input wire logic       transfer_ok,
    input wire logic       run_last
);

    logic        out_stall;
    logic        out_take;
    logic [11:0] out_word;

    assign out_stall = out_valid && !out_ready;
    assign out_take  = out_valid && out_ready;
    assign out_word  = {out_byte, is_payload, pair_crc_ok, transfer_ok, run_last};

    // stalled word holds
    `PCF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

    // a good check report is a zero, non-payload, final word
    `PCF_ASSERT_SAME(a_report_form, out_valid && pair_crc_ok, !is_payload && !(|out_byte) && run_last, "bad report")

    // only the payload byte of a pair can precede its crc
    `PCF_ASSERT_SAME(a_first_payload, out_valid && !run_last, is_payload && !pair_crc_ok, "bad first word")

    // the crc word follows its payload byte at once
    `PCF_ASSERT_NEXT(a_crc_follows, out_take && !run_last, out_valid && !is_payload && run_last, "crc word late")

    // nothing held back while the output is empty
    `PCF_ASSERT_SAME(a_in_open, !out_valid, in_ready, "input blocked with output empty")

endmodule

bind pairwise_crc8_framer_checker pcf_checker u_pcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .is_payload  (is_payload),
    .pair_crc_ok (pair_crc_ok),
    .transfer_ok (transfer_ok),
    .run_last    (run_last)
);

`default_nettype wire
